// File: rtl/core/wtm_pkg.sv
// ----------------------------------------------------------------------------
// wtm_pkg
// Shared widths, types and state codes for the window statistics unit.
// ----------------------------------------------------------------------------
package wtm_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int STAMP_BITS  = 32;
  localparam int COMP_BITS   = 16;
  localparam int COUNT_BITS  = 7;
  localparam int WINDOW_MAX  = 64;
  localparam int TRIM_LIMIT  = 2;
  // sum of WINDOW_MAX signed samples, sign included
  localparam int SUM_BITS    = SAMPLE_BITS + $clog2(WINDOW_MAX);
  localparam int STEP_BITS   = $clog2(SUM_BITS);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic        [STAMP_BITS-1:0]  stamp_t;
  typedef logic        [COMP_BITS-1:0]   comp_t;
  typedef logic        [COUNT_BITS-1:0]  count_t;

  // window statistics as seen after the current transaction
  typedef struct packed {
    sample_t latest;
    sample_t max_val;
    sample_t min_val;
    stamp_t  max_stamp;
    stamp_t  min_stamp;
    comp_t   side_at_max;
    count_t  count;
    logic    dropped;
  } win_stats_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } ctl_state_t;

endpackage

// File: rtl/core/wtm_accum.sv
// ----------------------------------------------------------------------------
// wtm_accum
// Running window statistics: extremes with stamps, sum, count, last sample.
// Produces the trimmed numerator and denominator for the closing sample.
// ----------------------------------------------------------------------------
module wtm_accum (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  logic                 closes,
  input  wtm_pkg::sample_t     sample,
  input  wtm_pkg::stamp_t      stamp,
  input  wtm_pkg::comp_t       companion,
  output wtm_pkg::win_stats_t  stats,
  output wtm_pkg::sum_t        num,
  output wtm_pkg::count_t      den
);

  wtm_pkg::win_stats_t win_r;
  wtm_pkg::win_stats_t win_nxt;
  wtm_pkg::sum_t       sum_r;
  wtm_pkg::sum_t       sum_nxt;
  logic                first;
  logic                full;

  assign first = (win_r.count == '0);
  assign full  = (win_r.count == wtm_pkg::count_t'(wtm_pkg::WINDOW_MAX));

  always_comb begin
    win_nxt = win_r;
    sum_nxt = sum_r;
    if (!full) begin
      if (first || (sample > win_r.max_val)) begin
        win_nxt.max_val     = sample;
        win_nxt.max_stamp   = stamp;
        win_nxt.side_at_max = companion;
      end
      if (first || (sample < win_r.min_val)) begin
        win_nxt.min_val   = sample;
        win_nxt.min_stamp = stamp;
      end
      sum_nxt        = sum_r + wtm_pkg::sum_t'(sample);
      win_nxt.count  = win_r.count + 1'b1;
      win_nxt.latest = sample;
    end else begin
      win_nxt.dropped = 1'b1;
    end
  end

  // trim largest and smallest once there are more than two samples
  always_comb begin
    if (win_nxt.count > wtm_pkg::count_t'(wtm_pkg::TRIM_LIMIT)) begin
      num = sum_nxt - wtm_pkg::sum_t'(win_nxt.max_val) - wtm_pkg::sum_t'(win_nxt.min_val);
      den = win_nxt.count - wtm_pkg::count_t'(wtm_pkg::TRIM_LIMIT);
    end else begin
      num = sum_nxt;
      den = win_nxt.count;
    end
  end

  assign stats = win_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      sum_r <= '0;
    end else if (take) begin
      if (closes) begin
        win_r <= '0;
        sum_r <= '0;
      end else begin
        win_r <= win_nxt;
        sum_r <= sum_nxt;
      end
    end
  end

endmodule

// File: rtl/core/wtm_div.sv
// ----------------------------------------------------------------------------
// wtm_div
// Bit-serial restoring divider, one quotient bit per cycle, truncating
// toward zero. The dividend register shifts out and takes quotient bits in.
// ----------------------------------------------------------------------------
module wtm_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  wtm_pkg::sum_t        num,
  input  wtm_pkg::count_t      den,
  output logic                 done,
  output wtm_pkg::sample_t     quot
);

  localparam int SB = wtm_pkg::SUM_BITS;
  localparam int CB = wtm_pkg::COUNT_BITS;

  logic [SB-1:0]                   dvd_r, dvd_nxt;
  logic [CB-1:0]                   rem_r, rem_nxt;
  logic [CB-1:0]                   den_r;
  logic                            neg_r;
  logic                            busy_r;
  logic                            done_r;
  logic [wtm_pkg::STEP_BITS-1:0]   step_r;
  logic [CB:0]                     shifted;
  logic [CB+1:0]                   diff;
  logic [SB-1:0]                   signed_q;

  assign shifted = {rem_r, dvd_r[SB-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_r};

  always_comb begin
    if (!diff[CB+1]) begin
      rem_nxt = diff[CB-1:0];
      dvd_nxt = {dvd_r[SB-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[CB-1:0];
      dvd_nxt = {dvd_r[SB-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= wtm_pkg::STEP_BITS'(SB - 1);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[SB-1];
      dvd_r <= num[SB-1] ? (-num) : num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign signed_q = neg_r ? (-dvd_r) : dvd_r;
  assign quot     = signed_q[wtm_pkg::SAMPLE_BITS-1:0];
  assign done     = done_r;

endmodule

// File: rtl/core/window_trimmed_mean_min_max_unit.sv
// Flow: a closing sample starts a bit-serial division (one quotient bit per
// cycle, 30 steps); its result is registered once the division is done and
// the output register is free, and no sample is taken until then.
// Throughput: one sample per cycle while idle, with no division or held result.
// Reset: synchronous active-low rst_n empties the window and the output register.
// ----------------------------------------------------------------------------
// window_trimmed_mean_min_max_unit
// Window statistics with trimmed mean, minimum, maximum and their stamps.
// ----------------------------------------------------------------------------
module window_trimmed_mean_min_max_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [23:0] sample, [55:24] stamp, [71:56] companion
  input  logic [71:0]  in_tdata,
  input  logic         in_tlast,    // closes_window
  output logic         out_tvalid,
  input  logic         out_tready,
  // [23:0] average, [47:24] current, [71:48] maximum, [95:72] minimum,
  // [127:96] time_of_max, [159:128] time_of_min, [175:160] companion_at_max,
  // [182:176] sample_count, [183] zero
  output logic [183:0] out_tdata,
  output logic         out_tuser    // overflowed
);

  wtm_pkg::ctl_state_t state_r, state_nxt;
  wtm_pkg::win_stats_t stats;
  wtm_pkg::win_stats_t snap_r;
  wtm_pkg::sum_t       num;
  wtm_pkg::count_t     den;
  wtm_pkg::sample_t    quot;
  logic                div_done;
  logic                take;
  logic                close_take;
  logic                load_out;
  logic                out_free;
  logic                out_tvalid_r;
  logic [183:0]        out_tdata_r;
  logic                out_tuser_r;

  assign in_tready  = (state_r == wtm_pkg::ST_IDLE);
  assign take       = in_tvalid && in_tready;
  assign close_take = take && in_tlast;
  assign out_free   = !out_tvalid_r || out_tready;

  wtm_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .closes    (in_tlast),
    .sample    (in_tdata[23:0]),
    .stamp     (in_tdata[55:24]),
    .companion (in_tdata[71:56]),
    .stats     (stats),
    .num       (num),
    .den       (den)
  );

  wtm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (close_take),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wtm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    case (state_r)
      wtm_pkg::ST_IDLE: begin
        if (close_take) state_nxt = wtm_pkg::ST_DIV;
      end
      wtm_pkg::ST_DIV: begin
        if (div_done) begin
          if (out_free) begin
            load_out  = 1'b1;
            state_nxt = wtm_pkg::ST_IDLE;
          end else begin
            state_nxt = wtm_pkg::ST_HOLD;
          end
        end
      end
      wtm_pkg::ST_HOLD: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = wtm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wtm_pkg::ST_IDLE;
    endcase
  end

  // statistics of the closing window, held while the quotient is formed
  always_ff @(posedge clk) begin
    if (close_take) snap_r <= stats;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_tdata_r <= {1'b0, snap_r.count, snap_r.side_at_max, snap_r.min_stamp,
                      snap_r.max_stamp, snap_r.min_val, snap_r.max_val,
                      snap_r.latest, quot};
      out_tuser_r <= snap_r.dropped;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// File: bench/window_stats_checker.sv
// ----------------------------------------------------------------------------
// window_stats_checker
// Watches both streams of the window statistics unit, folds every accepted
// sample into its own copy of the open window and, on a closing sample,
// queues the summary it expects. Each result transaction is compared field
// by field with the oldest queued summary.
// ----------------------------------------------------------------------------
module window_stats_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [71:0]  in_tdata,
  input  logic         in_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [183:0] out_tdata,
  input  logic         out_tuser,
  output int           fail_count,
  output int           pending_results
);

  typedef struct {
    logic [wtm_pkg::SAMPLE_BITS-1:0] average;
    logic [wtm_pkg::SAMPLE_BITS-1:0] current;
    logic [wtm_pkg::SAMPLE_BITS-1:0] maximum;
    logic [wtm_pkg::SAMPLE_BITS-1:0] minimum;
    wtm_pkg::stamp_t                 time_of_max;
    wtm_pkg::stamp_t                 time_of_min;
    wtm_pkg::comp_t                  companion_at_max;
    wtm_pkg::count_t                 sample_count;
    logic                            overflowed;
  } window_summary_t;

  window_summary_t window_summaries[$];

  // open window as the unit should hold it
  wtm_pkg::sample_t win_hi;
  wtm_pkg::sample_t win_lo;
  wtm_pkg::sample_t last_kept;
  wtm_pkg::sum_t    win_total;
  wtm_pkg::count_t  win_n;
  wtm_pkg::stamp_t  hi_stamp;
  wtm_pkg::stamp_t  lo_stamp;
  wtm_pkg::comp_t   hi_side;
  logic             spilled;

  int mismatches = 0;

  task automatic clear_window();
    win_hi    = '0;
    win_lo    = '0;
    last_kept = '0;
    win_total = '0;
    win_n     = '0;
    hi_stamp  = '0;
    lo_stamp  = '0;
    hi_side   = '0;
    spilled   = 1'b0;
  endtask

  task automatic fold_sample(input wtm_pkg::sample_t s, input wtm_pkg::stamp_t st,
                             input wtm_pkg::comp_t c, input logic closes);
    window_summary_t sum_out;
    wtm_pkg::sum_t   numer;
    longint          denom;
    longint          quotient;
    if (win_n < wtm_pkg::WINDOW_MAX) begin
      if (win_n == 0) begin
        win_hi   = s;
        win_lo   = s;
        hi_stamp = st;
        lo_stamp = st;
        hi_side  = c;
      end else begin
        // strict compares: first occurrence of an extreme stays
        if (s > win_hi) begin
          win_hi   = s;
          hi_stamp = st;
          hi_side  = c;
        end
        if (s < win_lo) begin
          win_lo   = s;
          lo_stamp = st;
        end
      end
      win_total = win_total + s;
      win_n     = win_n + 1'b1;
      last_kept = s;
    end else begin
      spilled = 1'b1;
    end
    if (closes) begin
      numer = win_total;
      denom = longint'(win_n);
      if (win_n > wtm_pkg::TRIM_LIMIT) begin
        numer = win_total - win_hi - win_lo;
        denom = longint'(win_n) - wtm_pkg::TRIM_LIMIT;
      end
      quotient = (denom > 0) ? longint'(numer) / denom : 0;
      sum_out.average          = quotient[wtm_pkg::SAMPLE_BITS-1:0];
      sum_out.current          = last_kept;
      sum_out.maximum          = win_hi;
      sum_out.minimum          = win_lo;
      sum_out.time_of_max      = hi_stamp;
      sum_out.time_of_min      = lo_stamp;
      sum_out.companion_at_max = hi_side;
      sum_out.sample_count     = win_n;
      sum_out.overflowed       = spilled;
      window_summaries.push_back(sum_out);
      clear_window();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  task automatic take_result();
    window_summary_t want;
    if (window_summaries.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result transaction, expected none, actual %h",
               $time, out_tdata);
    end else begin
      want = window_summaries.pop_front();
      check_field("average",          32'(out_tdata[23:0]),    32'(want.average));
      check_field("current",          32'(out_tdata[47:24]),   32'(want.current));
      check_field("maximum",          32'(out_tdata[71:48]),   32'(want.maximum));
      check_field("minimum",          32'(out_tdata[95:72]),   32'(want.minimum));
      check_field("time_of_max",      out_tdata[127:96],       want.time_of_max);
      check_field("time_of_min",      out_tdata[159:128],      want.time_of_min);
      check_field("companion_at_max", 32'(out_tdata[175:160]),
                  32'(want.companion_at_max));
      check_field("sample_count",     32'(out_tdata[182:176]), 32'(want.sample_count));
      check_field("pad bit",          32'(out_tdata[183]),     32'd0);
      check_field("overflowed",       32'(out_tuser),          32'(want.overflowed));
    end
  endtask

  initial clear_window();

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_window();
    end else begin
      if (out_tvalid && out_tready)
        take_result();
      if (in_tvalid && in_tready)
        fold_sample(in_tdata[23:0], in_tdata[55:24], in_tdata[71:56], in_tlast);
    end
    fail_count      <= mismatches;
    pending_results <= window_summaries.size();
  end

endmodule

// File: bench/window_trimmed_mean_min_max_unit_tb.sv
// ----------------------------------------------------------------------------
// window_trimmed_mean_min_max_unit_tb
// Drives windows of samples into the unit: a few hand-picked windows for
// extremes, ties and negative truncation, then random windows of mixed
// length, some past capacity. Both streams idle at random; the checker
// beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module window_trimmed_mean_min_max_unit_tb;

  localparam int          RANDOM_ITEMS = 1400;
  localparam int          DRAIN_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [71:0]  in_tdata;   // [23:0] sample, [55:24] stamp, [71:56] companion
  logic         in_tlast;   // closes_window
  logic         out_tvalid;
  logic         out_tready;
  logic [183:0] out_tdata;  // average, current, maximum, minimum, stamps, side, count
  logic         out_tuser;  // overflowed

  int          fail_count;
  int          pending_results;
  int unsigned cycle_count;
  int          items_sent;

  window_trimmed_mean_min_max_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  window_stats_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // mostly none, sometimes short, rarely long
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic wtm_pkg::sample_t pick_sample(input int style);
    case (style)
      0: return wtm_pkg::sample_t'($urandom);
      1: return wtm_pkg::sample_t'(int'($urandom_range(0, 8)) - 4);  // many ties
      2: begin
        case ($urandom_range(0, 4))
          0: return {1'b0, {(wtm_pkg::SAMPLE_BITS-1){1'b1}}};
          1: return {1'b1, {(wtm_pkg::SAMPLE_BITS-1){1'b0}}};
          2: return '0;
          3: return '1;
          default: return wtm_pkg::sample_t'(1);
        endcase
      end
      default: begin
        if ($urandom_range(0, 1) == 0)
          return wtm_pkg::sample_t'($urandom_range(0, 8388607));
        return wtm_pkg::sample_t'(-int'($urandom_range(1, 8388608)));
      end
    endcase
  endfunction

  // one input transaction, presented after an idle gap set by gap
  task automatic send_sample(input wtm_pkg::sample_t s, input wtm_pkg::stamp_t st,
                             input wtm_pkg::comp_t c, input logic closes,
                             input int gap);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = {c, st, s};
    in_tlast  = closes;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  initial begin
    int              r;
    int              win_len;
    int              style;
    int              k;
    logic            burst;
    wtm_pkg::stamp_t stamp;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    items_sent = 0;
    stamp      = 32'd100;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // single-sample windows at both extremes of every field
    send_sample(24'sh7FFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, idle_cycles());
    send_sample(24'sh800000, 32'h0000_0000, 16'h0000, 1'b1, idle_cycles());
    // two samples: no trimming, -3/2 truncates to -1
    send_sample(-24'sd1, 32'd1, 16'h0101, 1'b0, idle_cycles());
    send_sample(-24'sd2, 32'd2, 16'h0202, 1'b1, idle_cycles());
    // all equal: first occurrence keeps max and min
    send_sample(24'sd5, 32'd10, 16'd1, 1'b0, idle_cycles());
    send_sample(24'sd5, 32'd11, 16'd2, 1'b0, idle_cycles());
    send_sample(24'sd5, 32'd12, 16'd3, 1'b1, idle_cycles());
    // repeated extremes of the sample range
    send_sample(24'sh7FFFFF, 32'h8000_0000, 16'hAAAA, 1'b0, idle_cycles());
    send_sample(24'sh800000, 32'h8000_0001, 16'h5555, 1'b0, idle_cycles());
    send_sample(24'sh7FFFFF, 32'h8000_0002, 16'h1234, 1'b0, idle_cycles());
    send_sample(24'sh800000, 32'h8000_0003, 16'h4321, 1'b1, idle_cycles());
    // trimmed mean -11/3 truncates toward zero
    send_sample(-24'sd7,  32'd20, 16'd7, 1'b0, idle_cycles());
    send_sample(-24'sd3,  32'd21, 16'd8, 1'b0, idle_cycles());
    send_sample(-24'sd10, 32'd22, 16'd9, 1'b0, idle_cycles());
    send_sample(-24'sd1,  32'd23, 16'd10, 1'b0, idle_cycles());
    send_sample(24'sd4,   32'd24, 16'd11, 1'b1, idle_cycles());

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 60) win_len = $urandom_range(1, 8);
      else if (r < 80) win_len = $urandom_range(9, 30);
      else if (r < 90) win_len = $urandom_range(1, 3);
      else win_len = $urandom_range(60, 72);  // around capacity, drops included
      style = $urandom_range(0, 3);
      burst = ($urandom_range(0, 4) == 0);
      for (k = 0; k < win_len; k++) begin
        if ($urandom_range(0, 9) == 0) stamp = $urandom;
        else stamp = stamp + $urandom_range(1, 5);
        send_sample(pick_sample(style), stamp, wtm_pkg::comp_t'($urandom),
                    k == win_len - 1, burst ? 0 : idle_cycles());
      end
    end
    @(negedge clk);
    in_tvalid = 1'b0;

    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // result side back-pressure
  initial begin
    int hold;
    int stall;
    out_tready = 1'b1;
    forever begin
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 400) : $urandom_range(1, 40);
      repeat (hold) @(negedge clk);
      stall = idle_cycles();
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
        out_tready = 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
